// ===== rtl/bpd_pkg.sv =====
// Shared types and constants for the bilinear particle deposit block.
package bpd_pkg;

	// Operation codes of an input transaction.
	localparam logic [1:0] OP_DEPOSIT  = 2'd0;
	localparam logic [1:0] OP_READ     = 2'd1;
	localparam logic [1:0] OP_READ_CLR = 2'd2;
	localparam logic [1:0] OP_UNUSED   = 2'd3;

	// Result status codes.
	localparam logic [1:0] STS_OK      = 2'd0;
	localparam logic [1:0] STS_OUTSIDE = 2'd1;
	localparam logic [1:0] STS_SAT     = 2'd2;

	// Configuration register word indexes.
	localparam logic REG_INV_X = 1'b0;
	localparam logic REG_INV_Y = 1'b1;

	localparam logic [31:0] INV_RESET = 32'h0001_0000;
	localparam logic [16:0] ONE_Q16   = 17'h1_0000;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [15:0] cell_index;
	} in_item_t;

	typedef struct packed {
		logic [47:0] density;
		logic [1:0]  status;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MULX,
		ST_MULY,
		ST_CHECK,
		ST_CRD,
		ST_CWR,
		ST_DOUT,
		ST_RRD,
		ST_ROUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic mulx;
		logic muly;
		logic check;
		logic crd;
		logic cwr;
		logic dout;
		logic rrd;
		logic rout;
		logic clr;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_done;
		logic outside;
		logic corner_last;
	} sts_t;

endpackage

// ===== rtl/bpd_ctrl.sv =====
// Controller state machine that sequences deposits, reads and the clearing pass.
module bpd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        op,
	input  bpd_pkg::sts_t     sts,
	output bpd_pkg::cmd_t     cmd,
	output logic              busy
);

	bpd_pkg::state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpd_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			bpd_pkg::ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_done) state_d = bpd_pkg::ST_IDLE;
			end
			bpd_pkg::ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (op == bpd_pkg::OP_DEPOSIT) state_d = bpd_pkg::ST_MULX;
					else state_d = bpd_pkg::ST_RRD;
				end
			end
			bpd_pkg::ST_MULX: begin
				cmd.mulx = 1'b1;
				state_d  = bpd_pkg::ST_MULY;
			end
			bpd_pkg::ST_MULY: begin
				cmd.muly = 1'b1;
				state_d  = bpd_pkg::ST_CHECK;
			end
			bpd_pkg::ST_CHECK: begin
				cmd.check = 1'b1;
				state_d   = sts.outside ? bpd_pkg::ST_DOUT : bpd_pkg::ST_CRD;
			end
			bpd_pkg::ST_CRD: begin
				cmd.crd = 1'b1;
				state_d = bpd_pkg::ST_CWR;
			end
			bpd_pkg::ST_CWR: begin
				cmd.cwr = 1'b1;
				state_d = sts.corner_last ? bpd_pkg::ST_DOUT : bpd_pkg::ST_CRD;
			end
			bpd_pkg::ST_DOUT: begin
				cmd.dout = 1'b1;
				state_d  = bpd_pkg::ST_IDLE;
			end
			bpd_pkg::ST_RRD: begin
				cmd.rrd = 1'b1;
				state_d = bpd_pkg::ST_ROUT;
			end
			bpd_pkg::ST_ROUT: begin
				cmd.rout = 1'b1;
				state_d  = bpd_pkg::ST_IDLE;
			end
			default: begin
				state_d = bpd_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != bpd_pkg::ST_IDLE);

endmodule

// ===== rtl/bpd_datapath.sv =====
// Datapath: position scaling, weight multiplier, density memory and result register.
module bpd_datapath #(
	parameter int GRID_X = 256,
	parameter int GRID_Y = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bpd_pkg::cmd_t         cmd,
	input  bpd_pkg::in_item_t     item,
	input  logic [31:0]           inv_cell_x,
	input  logic [31:0]           inv_cell_y,
	output bpd_pkg::sts_t         sts,
	output bpd_pkg::out_item_t    result,
	output logic                  result_valid
);

	localparam int unsigned CELLS = GRID_X * GRID_Y;
	localparam int AW = $clog2(CELLS);
	localparam int IW = $clog2(GRID_X);
	localparam int YW = $clog2(GRID_Y);
	localparam logic [32:0] LIM_X = 33'(GRID_X - 2);
	localparam logic [32:0] LIM_Y = 33'(GRID_Y - 2);
	localparam logic [AW-1:0] LAST_ADDR = AW'(CELLS - 1);
	localparam logic [AW-1:0] ROW_STEP = AW'(GRID_Y);

	bpd_pkg::in_item_t item_q;
	logic [63:0]       gx_q, gy_q;
	logic [15:0]       fx_q, fy_q;
	logic [AW-1:0]     base_q, addr_q, clr_q;
	logic [1:0]        corner_q;
	logic              sat_q;
	logic [16:0]       weight_q;
	logic [47:0]       rdata_q;
	logic [47:0]       mem [CELLS];

	logic [32:0]       ix_c, iy_c;
	logic              outside_c, rd_ok_c;
	logic [16:0]       mul_a, mul_b;
	logic [33:0]       prod_c;
	logic [AW-1:0]     corner_addr, mem_addr;
	logic [48:0]       sum_c;
	logic [47:0]       sat_sum_c, wdata;
	logic              we;

	// Grid coordinates and the out-of-grid test.
	assign ix_c      = {1'b0, gx_q[63:32]} + 33'd1;
	assign iy_c      = {1'b0, gy_q[63:32]} + 33'd1;
	assign outside_c = (ix_c > LIM_X) || (iy_c > LIM_Y);
	assign rd_ok_c   = (32'(item_q.cell_index) < 32'(CELLS));

	// Weight factor selection for each corner of the cell.
	always_comb begin
		case (corner_q)
			2'd0: begin
				mul_a = bpd_pkg::ONE_Q16 - {1'b0, fx_q};
				mul_b = bpd_pkg::ONE_Q16 - {1'b0, fy_q};
			end
			2'd1: begin
				mul_a = bpd_pkg::ONE_Q16 - {1'b0, fx_q};
				mul_b = {1'b0, fy_q};
			end
			2'd2: begin
				mul_a = {1'b0, fx_q};
				mul_b = {1'b0, fy_q};
			end
			default: begin
				mul_a = {1'b0, fx_q};
				mul_b = bpd_pkg::ONE_Q16 - {1'b0, fy_q};
			end
		endcase
		case (corner_q)
			2'd0:    corner_addr = base_q;
			2'd1:    corner_addr = base_q + AW'(1);
			2'd2:    corner_addr = base_q + ROW_STEP + AW'(1);
			default: corner_addr = base_q + ROW_STEP;
		endcase
	end
	assign prod_c = 34'(mul_a) * 34'(mul_b);

	// Saturating accumulate.
	assign sum_c     = {1'b0, rdata_q} + {32'd0, weight_q};
	assign sat_sum_c = sum_c[48] ? '1 : sum_c[47:0];

	// Memory port selection: one access per cycle.
	always_comb begin
		we       = 1'b0;
		wdata    = '0;
		mem_addr = corner_addr;
		if (cmd.clr) begin
			we       = 1'b1;
			mem_addr = clr_q;
		end else if (cmd.cwr) begin
			we       = 1'b1;
			wdata    = sat_sum_c;
			mem_addr = addr_q;
		end else if (cmd.rrd) begin
			mem_addr = AW'(item_q.cell_index);
		end else if (cmd.rout) begin
			we       = rd_ok_c && (item_q.op == bpd_pkg::OP_READ_CLR);
			mem_addr = AW'(item_q.cell_index);
		end
	end

	// Density memory, single port with registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[mem_addr] <= wdata;
		end else begin
			rdata_q <= mem[mem_addr];
		end
	end

	// Payload registers of the item in flight.
	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= item;
		if (cmd.mulx) gx_q <= 64'(item_q.pos_x) * 64'(inv_cell_x);
		if (cmd.muly) gy_q <= 64'(item_q.pos_y) * 64'(inv_cell_y);
		if (cmd.check) begin
			fx_q   <= gx_q[31:16];
			fy_q   <= gy_q[31:16];
			base_q <= AW'(ix_c[IW-1:0]) * ROW_STEP + AW'(iy_c[YW-1:0]);
		end
		if (cmd.crd) begin
			weight_q <= prod_c[32:16];
			addr_q   <= corner_addr;
		end
	end

	// Corner counter, saturation flag and clearing counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_q <= '0;
			sat_q    <= 1'b0;
			clr_q    <= '0;
		end else begin
			if (cmd.check) begin
				corner_q <= '0;
				sat_q    <= 1'b0;
			end else if (cmd.cwr) begin
				corner_q <= corner_q + 2'd1;
				sat_q    <= sat_q | sum_c[48];
			end
			if (cmd.clr) clr_q <= clr_q + AW'(1);
		end
	end

	assign sts.clr_done    = (clr_q == LAST_ADDR);
	assign sts.outside     = outside_c;
	assign sts.corner_last = (corner_q == 2'd3);

	// Result register and its one-cycle strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= cmd.dout | cmd.rout;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.dout) begin
			result.density <= '0;
			if (outside_c) result.status <= bpd_pkg::STS_OUTSIDE;
			else if (sat_q) result.status <= bpd_pkg::STS_SAT;
			else result.status <= bpd_pkg::STS_OK;
		end else if (cmd.rout) begin
			if (item_q.op == bpd_pkg::OP_READ || item_q.op == bpd_pkg::OP_READ_CLR) begin
				result.density <= rd_ok_c ? rdata_q : '0;
				result.status  <= rd_ok_c ? bpd_pkg::STS_OK : bpd_pkg::STS_OUTSIDE;
			end else begin
				result.density <= '0;
				result.status  <= bpd_pkg::STS_OK;
			end
		end
	end

	// A result strobe is never asserted back to back.
	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe held for two cycles");

	// A deposit weight never exceeds one.
	a_weight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cwr |-> (weight_q <= bpd_pkg::ONE_Q16))
		else $error("deposit weight above one");

	// Error statuses carry zero density.
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.status != bpd_pkg::STS_OK) |-> (result.density == '0))
		else $error("nonzero density with error status");

endmodule

// ===== rtl/bilinear_particle_deposit.sv =====
// Top level of the bilinear particle deposit block: register port and core wiring.
//
// Usage: a transaction on the command channel is taken at a clock edge with
// start high and busy low. Op deposit scales the particle position by the
// inverse cell sizes, adds four bilinear weights into the density memory and
// reports status; op read returns one cell, and read-and-clear also zeroes it.
// Every transaction gives one result, shown for exactly one cycle with
// result_valid high; the receiver cannot hold it off.
// Sequence: a deposit scales the position in x, then y, does a grid check,
// then a read and a write on the single memory port for each of the four
// corners, then gives its result; an out-of-grid deposit goes from the check
// to its result. A read does a memory read, then gives its result. A new
// transaction may be started the cycle busy falls, and none overlap.
// Reset: the registers return to 1.0 and a clearing pass writes zero to all
// GRID_X*GRID_Y cells, one per cycle, with busy high until the pass ends.
// Configuration writes over the register port are taken at any time.
module bilinear_particle_deposit #(
	parameter int GRID_X = 256,
	parameter int GRID_Y = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  bpd_pkg::in_item_t     item,
	output bpd_pkg::out_item_t    result,
	output logic                  result_valid,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	logic [31:0]   inv_x_q, inv_y_q;
	bpd_pkg::cmd_t cmd;
	bpd_pkg::sts_t sts;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_x_q <= bpd_pkg::INV_RESET;
			inv_y_q <= bpd_pkg::INV_RESET;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == bpd_pkg::REG_INV_X) inv_x_q <= pwdata;
			else inv_y_q <= pwdata;
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == bpd_pkg::REG_INV_X) ? inv_x_q : inv_y_q;

	bpd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (item.op),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	bpd_datapath #(
		.GRID_X (GRID_X),
		.GRID_Y (GRID_Y)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.item         (item),
		.inv_cell_x   (inv_x_q),
		.inv_cell_y   (inv_y_q),
		.sts          (sts),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule
